### hw/rtl/amp_pkg.sv
// ============================================================================
// amp_pkg - shared types and constants for the adjacency matrix product
// Holds the sequencer states, the token that walks the multiply-accumulate
// pipeline and the status bundle that pipeline reports back.
// ============================================================================
package amp_pkg;

   localparam int IDX_W  = 3;   // row and column index width
   localparam int DATA_W = 32;  // matrix entry width
   localparam int CNT_W  = 7;   // nonzero count width
   localparam int CSR_W  = 4;   // vertex count register width

   localparam logic [CSR_W-1:0] VERTEX_COUNT_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CALC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic    valid;
      logic    first;
      logic    last;
      idx_type row;
      idx_type col;
   } mac_tok_type;

   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] nonzero_count;
      logic             not_symmetric;
   } mac_stat_type;

endpackage

### hw/rtl/adjacency_matrix_product.sv
// ============================================================================
// adjacency_matrix_product - integer product of two square matrices
// Loads two n by n matrices, multiplies them and streams out the product.
// ============================================================================
// Usage:
//   Write n (1 to MAX_VERTICES; 0 acts as 1, larger values as MAX_VERTICES)
//   through csr_wr_en/csr_wr_data while the block is idle; a write also
//   restarts loading at the first left entry.
//   Feed n*n left entries, then n*n right entries, row-major, on
//   req_entry_value; an entry transfers on a clock edge with start high and
//   busy low. Loading takes one entry per cycle.
//   After the last right entry busy rises. The product is computed
//   one multiply-accumulate per cycle from the operand memories, after
//   which the pipeline drains. Then the n*n product entries leave row-major,
//   one per cycle on consecutive cycles, each marked by rsp_strobe for one
//   cycle. The last one carries the nonzero count and the symmetry flag.
//   The receiver cannot stall; every strobed result is a completed transfer.
//   Reset sets n to 8, empties the load position and drops busy. The
//   operand and product memories are not cleared.
// ============================================================================
module adjacency_matrix_product #(
   parameter int MAX_VERTICES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [amp_pkg::CSR_W-1:0]         csr_wr_data,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [amp_pkg::DATA_W-1:0] req_entry_value,
   output logic                              rsp_strobe,
   output logic signed [amp_pkg::DATA_W-1:0] rsp_product_value,
   output logic [amp_pkg::IDX_W-1:0]         rsp_row_index,
   output logic [amp_pkg::IDX_W-1:0]         rsp_col_index,
   output logic                              rsp_last_entry,
   output logic [amp_pkg::CNT_W-1:0]         rsp_nonzero_count,
   output logic                              rsp_not_symmetric
);

   localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int AW = 2 * IW;

   amp_pkg::state_type          state_ff, state_in;
   logic [amp_pkg::CSR_W-1:0]   vc_ff, vc_dec;
   amp_pkg::idx_type            nm1;
   amp_pkg::idx_type            row_ff, row_in, col_ff, col_in, k_ff, k_in;
   logic                        right_ff, right_in;
   logic                        accept, clear;
   logic                        row_end, col_end, k_end;
   amp_pkg::mac_tok_type        issue_tok;
   amp_pkg::mac_stat_type       stat;
   logic                        out_strobe_in, out_last_in;
   logic                        out_strobe_ff, out_last_ff;
   amp_pkg::idx_type            out_row_ff, out_col_ff;

   logic [amp_pkg::DATA_W-1:0]  left_rd, right_rd, prd_rd;
   logic [AW-1:0]               sym_addr, prd_wr_addr, prd_rd_addr;
   logic                        prd_wr_en;
   logic [amp_pkg::DATA_W-1:0]  prd_wr_data;

   // Effective size minus one, with the out-of-range codes folded in.
   assign vc_dec = vc_ff - 1'b1;
   always_comb begin
      if (vc_ff == '0) begin
         nm1 = '0;
      end else if (vc_ff > amp_pkg::CSR_W'(MAX_VERTICES)) begin
         nm1 = amp_pkg::IDX_W'(MAX_VERTICES - 1);
      end else begin
         nm1 = vc_dec[amp_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= amp_pkg::VERTEX_COUNT_RESET;
      end else if (csr_wr_en) begin
         vc_ff <= csr_wr_data;
      end
   end

   assign busy    = (state_ff != amp_pkg::ST_LOAD);
   assign accept  = start && !busy;
   assign row_end = (row_ff == nm1);
   assign col_end = (col_ff == nm1);
   assign k_end   = (k_ff == nm1);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      k_in          = k_ff;
      right_in      = right_ff;
      clear         = 1'b0;
      out_strobe_in = 1'b0;
      out_last_in   = 1'b0;
      issue_tok     = '0;
      unique case (state_ff)
         amp_pkg::ST_LOAD: begin
            if (csr_wr_en) begin
               row_in   = '0;
               col_in   = '0;
               right_in = 1'b0;
            end else if (accept) begin
               col_in = col_end ? '0 : col_ff + 1'b1;
               if (col_end) begin
                  row_in = row_end ? '0 : row_ff + 1'b1;
                  if (row_end) begin
                     right_in = !right_ff;
                     if (right_ff) begin
                        clear    = 1'b1;
                        k_in     = '0;
                        state_in = amp_pkg::ST_CALC;
                     end
                  end
               end
            end
         end
         amp_pkg::ST_CALC: begin
            issue_tok.valid = 1'b1;
            issue_tok.first = (k_ff == '0);
            issue_tok.last  = k_end;
            issue_tok.row   = row_ff;
            issue_tok.col   = col_ff;
            k_in = k_end ? '0 : k_ff + 1'b1;
            if (k_end) begin
               col_in = col_end ? '0 : col_ff + 1'b1;
               if (col_end) begin
                  row_in = row_end ? '0 : row_ff + 1'b1;
                  if (row_end) begin
                     state_in = amp_pkg::ST_DRAIN;
                  end
               end
            end
         end
         amp_pkg::ST_DRAIN: begin
            if (!stat.busy) begin
               state_in = amp_pkg::ST_EMIT;
            end
         end
         amp_pkg::ST_EMIT: begin
            out_strobe_in = 1'b1;
            out_last_in   = row_end && col_end;
            col_in = col_end ? '0 : col_ff + 1'b1;
            if (col_end) begin
               row_in = row_end ? '0 : row_ff + 1'b1;
               if (row_end) begin
                  state_in = amp_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = amp_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= amp_pkg::ST_LOAD;
         row_ff        <= '0;
         col_ff        <= '0;
         k_ff          <= '0;
         right_ff      <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         k_ff          <= k_in;
         right_ff      <= right_in;
         out_strobe_ff <= out_strobe_in;
      end
      out_last_ff <= out_last_in;
      out_row_ff  <= row_ff;
      out_col_ff  <= col_ff;
   end

   amp_ram #(
      .WIDTH  (amp_pkg::DATA_W),
      .ADDR_W (AW)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (accept && !right_ff),
      .wr_addr ({row_ff[IW-1:0], col_ff[IW-1:0]}),
      .wr_data (req_entry_value),
      .rd_addr ({row_ff[IW-1:0], k_ff[IW-1:0]}),
      .rd_data (left_rd)
   );

   amp_ram #(
      .WIDTH  (amp_pkg::DATA_W),
      .ADDR_W (AW)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (accept && right_ff),
      .wr_addr ({row_ff[IW-1:0], col_ff[IW-1:0]}),
      .wr_data (req_entry_value),
      .rd_addr ({k_ff[IW-1:0], col_ff[IW-1:0]}),
      .rd_data (right_rd)
   );

   amp_mac #(
      .IW (IW)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .issue_tok   (issue_tok),
      .left_data   (left_rd),
      .right_data  (right_rd),
      .sym_data    (prd_rd),
      .sym_addr    (sym_addr),
      .prd_wr_en   (prd_wr_en),
      .prd_wr_addr (prd_wr_addr),
      .prd_wr_data (prd_wr_data),
      .stat        (stat)
   );

   // The product memory's read port serves the symmetry check while
   // computing and the result stream while emitting.
   assign prd_rd_addr = (state_ff == amp_pkg::ST_EMIT) ?
                        {row_ff[IW-1:0], col_ff[IW-1:0]} : sym_addr;

   amp_ram #(
      .WIDTH  (amp_pkg::DATA_W),
      .ADDR_W (AW)
   ) u_prd_ram (
      .clock   (clock),
      .wr_en   (prd_wr_en),
      .wr_addr (prd_wr_addr),
      .wr_data (prd_wr_data),
      .rd_addr (prd_rd_addr),
      .rd_data (prd_rd)
   );

   assign rsp_strobe        = out_strobe_ff;
   assign rsp_product_value = prd_rd;
   assign rsp_row_index     = out_row_ff;
   assign rsp_col_index     = out_col_ff;
   assign rsp_last_entry    = out_last_ff;
   assign rsp_nonzero_count = out_last_ff ? stat.nonzero_count : '0;
   assign rsp_not_symmetric = out_last_ff && stat.not_symmetric;

endmodule

### hw/rtl/amp_ram.sv
// ============================================================================
// amp_ram - simple dual-port synchronous memory
// One write port and one read port; read data is registered.
// ============================================================================
module amp_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/amp_mac.sv
// ============================================================================
// amp_mac - multiply-accumulate pipeline for one product entry at a time
// Stage 1 multiplies the operands read from the stores, stage 2 accumulates
// and, on the last term, writes the entry and updates the run statistics.
// ============================================================================
module amp_mac #(
   parameter int IW = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  amp_pkg::mac_tok_type       issue_tok,
   input  logic [amp_pkg::DATA_W-1:0] left_data,
   input  logic [amp_pkg::DATA_W-1:0] right_data,
   input  logic [amp_pkg::DATA_W-1:0] sym_data,
   output logic [2*IW-1:0]            sym_addr,
   output logic                       prd_wr_en,
   output logic [2*IW-1:0]            prd_wr_addr,
   output logic [amp_pkg::DATA_W-1:0] prd_wr_data,
   output amp_pkg::mac_stat_type      stat
);

   amp_pkg::mac_tok_type             tk1_ff, tk2_ff;
   logic [amp_pkg::DATA_W-1:0]       mul_ff, acc_ff, acc_in;
   logic [amp_pkg::CNT_W-1:0]        nz_ff, nz_in;
   logic                             asym_ff, asym_in;
   logic [2*amp_pkg::DATA_W-1:0]     mul_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         tk1_ff.valid <= 1'b0;
         tk2_ff.valid <= 1'b0;
      end else begin
         tk1_ff.valid <= issue_tok.valid;
         tk2_ff.valid <= tk1_ff.valid;
      end
      tk1_ff.first <= issue_tok.first;
      tk1_ff.last  <= issue_tok.last;
      tk1_ff.row   <= issue_tok.row;
      tk1_ff.col   <= issue_tok.col;
      tk2_ff.first <= tk1_ff.first;
      tk2_ff.last  <= tk1_ff.last;
      tk2_ff.row   <= tk1_ff.row;
      tk2_ff.col   <= tk1_ff.col;
   end

   // Only the low word of the product matters; signed and unsigned agree there.
   assign mul_full = left_data * right_data;

   always_ff @(posedge clock) begin
      mul_ff <= mul_full[amp_pkg::DATA_W-1:0];
      if (tk2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc_in = (tk2_ff.first ? '0 : acc_ff) + mul_ff;

   // The mirror entry lies in an earlier row, so it was written back
   // before this read is issued.
   assign sym_addr = {tk1_ff.col[IW-1:0], tk1_ff.row[IW-1:0]};

   always_comb begin
      nz_in   = nz_ff;
      asym_in = asym_ff;
      if (clear) begin
         nz_in   = '0;
         asym_in = 1'b0;
      end else if (tk2_ff.valid && tk2_ff.last) begin
         if (acc_in != '0) begin
            nz_in = nz_ff + 1'b1;
         end
         if ((tk2_ff.col < tk2_ff.row) && (acc_in != sym_data)) begin
            asym_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nz_ff   <= '0;
         asym_ff <= 1'b0;
      end else begin
         nz_ff   <= nz_in;
         asym_ff <= asym_in;
      end
   end

   assign prd_wr_en   = tk2_ff.valid && tk2_ff.last;
   assign prd_wr_addr = {tk2_ff.row[IW-1:0], tk2_ff.col[IW-1:0]};
   assign prd_wr_data = acc_in;

   assign stat.busy          = tk1_ff.valid || tk2_ff.valid;
   assign stat.nonzero_count = nz_ff;
   assign stat.not_symmetric = asym_ff;

endmodule

### hw/rtl/amp_checker.sv
// ============================================================================
// amp_checker - port-level checks for the adjacency matrix product
// Watches the result stream against the load handshake and itself.
// ============================================================================
module amp_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic [amp_pkg::IDX_W-1:0] rsp_row_index,
   input logic [amp_pkg::IDX_W-1:0] rsp_col_index,
   input logic                      rsp_last_entry,
   input logic [amp_pkg::CNT_W-1:0] rsp_nonzero_count,
   input logic                      rsp_not_symmetric
);

   // Results stream on consecutive cycles until the last one.
   a_stream_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_entry) |=> rsp_strobe)
      else $error("result stream broke before its last entry");

   // Only the final result may appear while the block accepts entries.
   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_entry) |-> busy)
      else $error("result emitted while block idle");

   // A loaded entry never yields a result in the next cycle.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result directly after an entry transfer");

   // Statistics appear only on the last result.
   a_stats_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_entry) |->
         (rsp_nonzero_count == '0) && !rsp_not_symmetric)
      else $error("statistics on a result that is not the last");

   // The last entry is on the diagonal.
   a_last_diagonal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_entry) |-> (rsp_row_index == rsp_col_index))
      else $error("last result is off the diagonal");

endmodule

bind adjacency_matrix_product amp_checker u_amp_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_row_index     (rsp_row_index),
   .rsp_col_index     (rsp_col_index),
   .rsp_last_entry    (rsp_last_entry),
   .rsp_nonzero_count (rsp_nonzero_count),
   .rsp_not_symmetric (rsp_not_symmetric)
);
